@@ src/itp_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and constants for the infix to postfix converter.
// Depends on nothing; every other file of the block imports it.
package itp_pkg;

   // Operator stack depth and the widths that follow from it.
   localparam int STACK_DEPTH = 16;
   localparam int SP_W        = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W       = $clog2(STACK_DEPTH);

   // Token kinds.
   localparam logic [1:0] KIND_NUM  = 2'd0;
   localparam logic [1:0] KIND_VAR  = 2'd1;
   localparam logic [1:0] KIND_FUNC = 2'd2;
   localparam logic [1:0] KIND_OPER = 2'd3;

   // Operator codes that steer the control flow.
   localparam logic [3:0] OPC_NONE   = 4'd0;
   localparam logic [3:0] OPC_MOD    = 4'd4;
   localparam logic [3:0] OPC_LPAREN = 4'd8;
   localparam logic [3:0] OPC_RPAREN = 4'd9;
   localparam logic [3:0] OPC_COMMA  = 4'd10;

   // Error codes.
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_PAREN    = 2'd1;
   localparam logic [1:0] ERR_OVERFLOW = 2'd2;

   // One token as it appears on the result side.
   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  opc;
      logic [63:0] value;
      logic [7:0]  name;
      logic [3:0]  argc;
   } tok_type;

   // One result word.
   typedef struct packed {
      tok_type    tok;
      logic       eoe;
      logic [1:0] err;
   } rsp_type;

   // One operator stack entry.
   typedef struct packed {
      logic       is_func;
      logic [3:0] opc;
      logic [7:0] name;
      logic [3:0] argc;
   } entry_type;

   // Command classes handed from the front to the back.
   typedef enum logic [2:0] {
      CMD_PASS,
      CMD_PUSH,
      CMD_COMMA,
      CMD_RPAREN,
      CMD_OPER,
      CMD_NOP
   } cls_type;

   typedef struct packed {
      cls_type    cls;
      tok_type    tok;
      entry_type  entry;
      logic [2:0] prec;
      logic       last;
   } cmd_type;

   // Binding strength of the arithmetic operators.
   function automatic logic [2:0] prec_of(input logic [2:0] code);
      logic [2:0] p;
      case (code) inside
         3'd0, 3'd1:       p = 3'd1;
         3'd2, 3'd3, 3'd4: p = 3'd2;
         3'd5, 3'd6:       p = 3'd3;
         default:          p = 3'd4;
      endcase
      return p;
   endfunction

endpackage

@@ src/itp_front.sv @@
`timescale 1ns / 1ps
// Front end: classifies each incoming token into a command and queues it.
// Depends on itp_pkg.
module itp_front
   import itp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  op,
   input  logic [3:0]  operator_code,
   input  logic [63:0] value_bits,
   input  logic [7:0]  name_index,
   input  logic [3:0]  argument_count,
   input  logic        last_token,
   output logic        cmd_valid,
   output cmd_type     cmd,
   input  logic        cmd_take
);

   cmd_type    cls_cmd;
   cmd_type    queue_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       wr_en;
   logic       rd_en;

   // Classify the token; fields unused by its kind stay zero but prec.
   always_comb begin
      cls_cmd       = '0;
      cls_cmd.cls   = CMD_NOP;
      cls_cmd.last  = last_token;
      cls_cmd.prec  = prec_of(operator_code[2:0]);
      case (op)
         KIND_NUM: begin
            cls_cmd.cls       = CMD_PASS;
            cls_cmd.tok.kind  = KIND_NUM;
            cls_cmd.tok.value = value_bits;
         end
         KIND_VAR: begin
            cls_cmd.cls      = CMD_PASS;
            cls_cmd.tok.kind = KIND_VAR;
            cls_cmd.tok.name = name_index;
         end
         KIND_FUNC: begin
            cls_cmd.cls           = CMD_PUSH;
            cls_cmd.entry.is_func = 1'b1;
            cls_cmd.entry.name    = name_index;
            cls_cmd.entry.argc    = argument_count;
         end
         default: begin
            case (operator_code)
               OPC_COMMA:  cls_cmd.cls = CMD_COMMA;
               OPC_RPAREN: cls_cmd.cls = CMD_RPAREN;
               OPC_LPAREN: begin
                  cls_cmd.cls       = CMD_PUSH;
                  cls_cmd.entry.opc = OPC_LPAREN;
               end
               default: begin
                  if (operator_code < OPC_LPAREN) begin
                     cls_cmd.cls       = CMD_OPER;
                     cls_cmd.entry.opc = operator_code;
                  end
               end
            endcase
         end
      endcase
   end

   // Two-word command queue between front and back.
   assign full      = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = queue_ff[rd_ptr_ff];
   assign wr_en     = push && !full;
   assign rd_en     = cmd_take && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ wr_en;
      rd_ptr_in = rd_ptr_ff ^ rd_en;
      count_in  = count_ff + {1'b0, wr_en} - {1'b0, rd_en};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         queue_ff[wr_ptr_ff] <= cls_cmd;
      end
   end

endmodule

@@ src/itp_rsp_fifo.sv @@
`timescale 1ns / 1ps
// Two-word result queue that parts the back end from the receiver.
// Depends on itp_pkg.
module itp_rsp_fifo
   import itp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    wr,
   input  rsp_type wr_data,
   output logic    wr_full,
   output logic    empty,
   input  logic    pop,
   output rsp_type rd_data
);

   rsp_type    mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       wr_en;
   logic       rd_en;

   // Occupancy and pointers.
   assign wr_full = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign rd_data = mem_ff[rd_ptr_ff];
   assign wr_en   = wr && !wr_full;
   assign rd_en   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ wr_en;
      rd_ptr_in = rd_ptr_ff ^ rd_en;
      count_in  = count_ff + {1'b0, wr_en} - {1'b0, rd_en};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

@@ src/itp_back.sv @@
`timescale 1ns / 1ps
// Back end: runs queued commands against the operator stack, at most one stack
// access and result word per cycle unless stalled. Depends on itp_pkg.
module itp_back
   import itp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    cmd_take,
   output logic    rsp_wr,
   output rsp_type rsp_data,
   input  logic    rsp_full
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MAIN,
      S_RFUNC,
      S_FLUSH,
      S_END
   } state_type;

   state_type   state_ff, state_in;
   cmd_type     cmd_ff, cmd_in;
   logic [SP_W-1:0] sp_ff, sp_in;
   logic        failed_ff, failed_in;
   logic [1:0]  code_ff, code_in;
   tok_type     hold_ff, hold_in;
   logic        hold_v_ff, hold_v_in;
   entry_type   stack_ff [STACK_DEPTH];

   logic [SP_W-1:0] sp_m1;
   entry_type   top;
   logic        sp_zero;
   logic        sp_full;
   logic        top_lparen;
   tok_type     pop_tok;
   logic        emit;
   tok_type     emit_tok;
   logic        push_req;
   logic        push_en;
   logic        wr_need;
   rsp_type     wr_data;
   logic        stall;
   logic        advance;
   logic        do_pop;
   logic        finish;
   logic [2:0]  top_prec;

   // Top of stack and what popping it would emit.
   assign sp_m1      = sp_ff - SP_W'(1);
   assign top        = stack_ff[sp_m1[IDX_W-1:0]];
   assign sp_zero    = (sp_ff == '0);
   assign sp_full    = (sp_ff == SP_W'(STACK_DEPTH));
   assign top_lparen = !top.is_func && (top.opc == OPC_LPAREN);
   assign top_prec   = prec_of(top.opc[2:0]);

   always_comb begin
      pop_tok = '0;
      if (top.is_func) begin
         pop_tok.kind = KIND_FUNC;
         pop_tok.name = top.name;
         pop_tok.argc = top.argc;
      end else begin
         pop_tok.kind = KIND_OPER;
         pop_tok.opc  = top.opc;
      end
   end

   // Sequencer: decide this cycle's stack action and result word.
   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      sp_in     = sp_ff;
      failed_in = failed_ff;
      code_in   = code_ff;
      hold_in   = hold_ff;
      hold_v_in = hold_v_ff;
      cmd_take  = 1'b0;
      emit      = 1'b0;
      emit_tok  = '0;
      push_req  = 1'b0;
      wr_need   = 1'b0;
      wr_data   = '0;
      advance   = 1'b0;
      do_pop    = 1'b0;
      finish    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_take = 1'b1;
               cmd_in   = cmd;
               state_in = S_MAIN;
            end
         end
         S_MAIN: begin
            if (failed_ff) begin
               advance = 1'b1;
            end else begin
               case (cmd_ff.cls)
                  CMD_PASS: begin
                     emit     = 1'b1;
                     emit_tok = cmd_ff.tok;
                     advance  = 1'b1;
                  end
                  CMD_PUSH: begin
                     push_req = 1'b1;
                     advance  = 1'b1;
                  end
                  CMD_COMMA: begin
                     if (!sp_zero && !top_lparen) begin
                        do_pop = 1'b1;
                     end else begin
                        advance = 1'b1;
                     end
                  end
                  CMD_RPAREN: begin
                     if (sp_zero) begin
                        failed_in = 1'b1;
                        code_in   = ERR_PAREN;
                        advance   = 1'b1;
                     end else if (top_lparen) begin
                        sp_in    = sp_m1;
                        state_in = S_RFUNC;
                     end else begin
                        do_pop = 1'b1;
                     end
                  end
                  CMD_OPER: begin
                     if (!sp_zero && !top.is_func && (top.opc < OPC_LPAREN) &&
                         ((top_prec > cmd_ff.prec) ||
                          ((top_prec == cmd_ff.prec) && (top.opc <= OPC_MOD)))) begin
                        do_pop = 1'b1;
                     end else begin
                        push_req = 1'b1;
                        advance  = 1'b1;
                     end
                  end
                  default: advance = 1'b1;
               endcase
            end
         end
         S_RFUNC: begin
            // A function directly under the matched parenthesis goes out too.
            if (!sp_zero && top.is_func) begin
               emit     = 1'b1;
               emit_tok = pop_tok;
               sp_in    = sp_m1;
            end
            advance = 1'b1;
         end
         S_FLUSH: begin
            if (failed_ff || sp_zero) begin
               state_in = S_END;
            end else if (top_lparen) begin
               failed_in = 1'b1;
               code_in   = ERR_PAREN;
               state_in  = S_END;
            end else begin
               do_pop = 1'b1;
            end
         end
         S_END: begin
            // The held word closes the expression unless an error marker follows.
            wr_need = 1'b1;
            if (hold_v_ff) begin
               wr_data.tok = hold_ff;
               wr_data.eoe = !failed_ff;
               hold_v_in   = 1'b0;
               finish      = !failed_ff;
            end else begin
               wr_data.eoe = 1'b1;
               wr_data.err = code_ff;
               finish      = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (do_pop) begin
         emit     = 1'b1;
         emit_tok = pop_tok;
         sp_in    = sp_m1;
      end

      if (push_req) begin
         if (sp_full) begin
            failed_in = 1'b1;
            code_in   = ERR_OVERFLOW;
         end else begin
            sp_in = sp_ff + SP_W'(1);
         end
      end

      if (advance) begin
         state_in = cmd_ff.last ? S_FLUSH : S_IDLE;
      end

      if (finish) begin
         sp_in     = '0;
         failed_in = 1'b0;
         code_in   = ERR_NONE;
         hold_v_in = 1'b0;
         state_in  = S_IDLE;
      end

      // Words of a last token pass through the hold register so the final
      // one can be marked; other words go straight to the result queue.
      if (emit) begin
         if (cmd_ff.last) begin
            if (hold_v_ff) begin
               wr_need     = 1'b1;
               wr_data.tok = hold_ff;
            end
            hold_in   = emit_tok;
            hold_v_in = 1'b1;
         end else begin
            wr_need     = 1'b1;
            wr_data.tok = emit_tok;
         end
      end

      stall = wr_need && rsp_full;
      if (stall) begin
         state_in  = state_ff;
         cmd_in    = cmd_ff;
         sp_in     = sp_ff;
         failed_in = failed_ff;
         code_in   = code_ff;
         hold_in   = hold_ff;
         hold_v_in = hold_v_ff;
      end
   end

   assign push_en  = push_req && !sp_full && !stall;
   assign rsp_wr   = wr_need && !stall;
   assign rsp_data = wr_data;

   // Sequencer state and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         sp_ff     <= '0;
         failed_ff <= 1'b0;
         code_ff   <= ERR_NONE;
         hold_v_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         sp_ff     <= sp_in;
         failed_ff <= failed_in;
         code_ff   <= code_in;
         hold_v_ff <= hold_v_in;
      end
      cmd_ff  <= cmd_in;
      hold_ff <= hold_in;
   end

   // Operator stack storage.
   always_ff @(posedge clock) begin
      if (push_en) begin
         stack_ff[sp_ff[IDX_W-1:0]] <= cmd_ff.entry;
      end
   end

`ifndef NO_ASSERTIONS
   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SP_W'(STACK_DEPTH))
      else $error("stack pointer beyond stack depth");

   a_no_write_full: assert property (@(posedge clock) disable iff (reset)
      rsp_wr |-> !rsp_full)
      else $error("result written into a full queue");

   a_idle_no_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !hold_v_ff)
      else $error("held result left over between expressions");

   a_fail_code: assert property (@(posedge clock) disable iff (reset)
      failed_ff |-> (code_ff != ERR_NONE))
      else $error("failure without an error code");

   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_take |=> (state_ff == S_MAIN))
      else $error("command taken but not started");
`endif

endmodule

@@ src/infix_to_postfix_converter.sv @@
`timescale 1ns / 1ps
// Infix to postfix converter, top level. Uses itp_pkg, itp_front, itp_back
// and itp_rsp_fifo.
//
// Input side is a queue: drive the token fields with push high; a word is
// taken on a clock edge where full is low. Tokens arrive already classified;
// req_last_token closes an expression and flushes the operator stack.
// Result side is a queue too: while empty is low the oldest postfix token is
// on the rsp_ ports and pop takes it. rsp_end_of_expression marks the final
// word of an expression, and rsp_error_code is nonzero only on the closing
// marker of a failed expression.
// A token is taken from the command queue in the back end's idle state and
// carried out in its main state, which pops one operator or function at a
// time; a right parenthesis then drops its matching left parenthesis and
// moves to a state in which a function below it leaves. A last token then
// flushes the stack one entry at a time and closes the expression, the held
// word going out ahead of an error marker when the expression failed. The
// back end takes a new token only when it is through with the last one; its
// sequencer makes one stack access a cycle while the result queue has room.
// A number or variable that does not end its expression goes from the main
// state straight into the result queue, not through the hold register.
// Synchronous reset empties both queues, the stack and the error state.
// When the receiver stalls, the result queue fills, the back end holds its
// state, then the command queue fills and full rises.
module infix_to_postfix_converter
   import itp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_op,
   input  logic [3:0]  req_operator_code,
   input  logic [63:0] req_value_bits,
   input  logic [7:0]  req_name_index,
   input  logic [3:0]  req_argument_count,
   input  logic        req_last_token,
   output logic        empty,
   input  logic        pop,
   output logic [1:0]  rsp_out_kind,
   output logic [3:0]  rsp_out_operator,
   output logic [63:0] rsp_out_value_bits,
   output logic [7:0]  rsp_out_name_index,
   output logic [3:0]  rsp_out_argument_count,
   output logic        rsp_end_of_expression,
   output logic [1:0]  rsp_error_code
);

   logic    cmd_valid;
   cmd_type cmd;
   logic    cmd_take;
   logic    rsp_wr;
   rsp_type rsp_wr_data;
   logic    rsp_full;
   rsp_type rsp_head;

   // Front end: classification and command queue.
   itp_front u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .op             (req_op),
      .operator_code  (req_operator_code),
      .value_bits     (req_value_bits),
      .name_index     (req_name_index),
      .argument_count (req_argument_count),
      .last_token     (req_last_token),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_take       (cmd_take)
   );

   // Back end: operator stack sequencer.
   itp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take),
      .rsp_wr    (rsp_wr),
      .rsp_data  (rsp_wr_data),
      .rsp_full  (rsp_full)
   );

   // Result queue towards the receiver.
   itp_rsp_fifo u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr      (rsp_wr),
      .wr_data (rsp_wr_data),
      .wr_full (rsp_full),
      .empty   (empty),
      .pop     (pop),
      .rd_data (rsp_head)
   );

   // Result word onto the ports.
   assign rsp_out_kind           = rsp_head.tok.kind;
   assign rsp_out_operator       = rsp_head.tok.opc;
   assign rsp_out_value_bits     = rsp_head.tok.value;
   assign rsp_out_name_index     = rsp_head.tok.name;
   assign rsp_out_argument_count = rsp_head.tok.argc;
   assign rsp_end_of_expression  = rsp_head.eoe;
   assign rsp_error_code         = rsp_head.err;

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for infix_to_postfix_converter: a scoreboard class predicts
// the postfix words of each token; plain tasks push tokens and a receiver process pops results.
// Depends on itp_pkg and the converter RTL; reads no files.
module tb;
   import itp_pkg::*;

   // Operator codes that the package leaves unnamed.
   localparam logic [3:0] OPC_ADD  = 4'd0;
   localparam logic [3:0] OPC_SUB  = 4'd1;
   localparam logic [3:0] OPC_MUL  = 4'd2;
   localparam logic [3:0] OPC_DIV  = 4'd3;
   localparam logic [3:0] OPC_POW  = 4'd5;
   localparam logic [3:0] OPC_SQRT = 4'd6;
   localparam logic [3:0] OPC_NEG  = 4'd7;
   localparam logic [3:0] OPC_BAD  = 4'd15;

   localparam int TOKEN_GOAL = 250;
   localparam int CLK_HALF   = 4;

   // One infix token as it is offered on the input side.
   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  opc;
      logic [63:0] value;
      logic [7:0]  name;
      logic [3:0]  argc;
      logic        last;
   } infix_tok_type;

   typedef enum {SHAPE_CLEAN, SHAPE_NEST, SHAPE_BROKEN, SHAPE_NOISE} shape_type;
   typedef enum {DRAIN_FREE, DRAIN_LIGHT, DRAIN_HALF, DRAIN_STARVED} drain_mode_type;

   // Shunting-yard predictor and the store of postfix words still due.
   class postfix_scoreboard;
      rsp_type     postfix_due[$];
      rsp_type     produced[$];
      entry_type   op_stack[STACK_DEPTH];
      int unsigned depth;
      bit          failed;
      logic [1:0]  fail_code;
      int unsigned mismatches;
      int unsigned words_checked;
      int unsigned expressions;
      int unsigned paren_errors;
      int unsigned overflow_errors;
      int unsigned empty_endings;

      function void emit(logic [1:0] kind, logic [3:0] opc, logic [63:0] value,
                         logic [7:0] name, logic [3:0] argc, logic [1:0] err);
         rsp_type w;
         w.tok.kind  = kind;
         w.tok.opc   = opc;
         w.tok.value = value;
         w.tok.name  = name;
         w.tok.argc  = argc;
         w.eoe       = 1'b0;
         w.err       = err;
         produced.insert(produced.size(), w);
      endfunction

      function void pop_entry();
         entry_type e;
         depth--;
         e = op_stack[depth];
         if (e.is_func)
            emit(KIND_FUNC, OPC_NONE, '0, e.name, e.argc, ERR_NONE);
         else
            emit(KIND_OPER, e.opc, '0, '0, '0, ERR_NONE);
      endfunction

      // A push onto a full stack drops the token and fails the expression.
      function void push_entry(entry_type e);
         if (depth >= STACK_DEPTH) begin
            failed    = 1'b1;
            fail_code = ERR_OVERFLOW;
         end else begin
            op_stack[depth] = e;
            depth++;
         end
      endfunction

      function bit lparen_on_top();
         return !op_stack[depth - 1].is_func && op_stack[depth - 1].opc == OPC_LPAREN;
      endfunction

      function int unsigned binding(logic [3:0] c);
         case (c)
            OPC_ADD, OPC_SUB:          return 1;
            OPC_MUL, OPC_DIV, OPC_MOD: return 2;
            OPC_POW, OPC_SQRT:         return 3;
            default:                   return 4;
         endcase
      endfunction

      function string describe(rsp_type w);
         return $sformatf("kind=%0d op=%0d value=%h name=%0d argc=%0d end=%0d err=%0d",
                          w.tok.kind, w.tok.opc, w.tok.value, w.tok.name, w.tok.argc,
                          w.eoe, w.err);
      endfunction

      function void complain(string msg);
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: MISMATCH %s", $time, msg);
      endfunction

      // Works out the words caused by one accepted token; returns 1 unless the
      // converter merely ignores the token.
      function bit note_token(infix_tok_type t);
         entry_type   e;
         entry_type   top_e;
         rsp_type     w;
         bit          effective;
         int unsigned p;
         effective = t.last || (!failed && !(t.kind == KIND_OPER && t.opc > OPC_COMMA));
         produced.delete();
         e = '0;
         if (!failed) begin
            case (t.kind)
               KIND_NUM: emit(KIND_NUM, OPC_NONE, t.value, '0, '0, ERR_NONE);
               KIND_VAR: emit(KIND_VAR, OPC_NONE, '0, t.name, '0, ERR_NONE);
               KIND_FUNC: begin
                  e.is_func = 1'b1;
                  e.name    = t.name;
                  e.argc    = t.argc;
                  push_entry(e);
               end
               default: begin
                  if (t.opc == OPC_COMMA) begin
                     while (depth > 0 && !lparen_on_top())
                        pop_entry();
                  end else if (t.opc == OPC_LPAREN) begin
                     e.opc = OPC_LPAREN;
                     push_entry(e);
                  end else if (t.opc == OPC_RPAREN) begin
                     // Pop down to the matching left parenthesis, then a function below it.
                     while (!failed && (depth == 0 || !lparen_on_top())) begin
                        if (depth == 0) begin
                           failed    = 1'b1;
                           fail_code = ERR_PAREN;
                        end else begin
                           pop_entry();
                        end
                     end
                     if (!failed) begin
                        depth--;
                        if (depth > 0 && op_stack[depth - 1].is_func)
                           pop_entry();
                     end
                  end else if (t.opc < OPC_LPAREN) begin
                     // Stronger operators leave first; equal ones only if left-associative.
                     p = binding(t.opc);
                     while (depth > 0) begin
                        top_e = op_stack[depth - 1];
                        if (top_e.is_func || top_e.opc >= OPC_LPAREN)
                           break;
                        if (binding(top_e.opc) > p ||
                            (binding(top_e.opc) == p && top_e.opc <= OPC_MOD))
                           pop_entry();
                        else
                           break;
                     end
                     e.opc = t.opc;
                     push_entry(e);
                  end
               end
            endcase
         end

         // The last token flushes the stack and closes the expression.
         if (t.last) begin
            expressions++;
            if (!failed) begin
               while (depth > 0) begin
                  if (lparen_on_top()) begin
                     failed    = 1'b1;
                     fail_code = ERR_PAREN;
                     break;
                  end
                  pop_entry();
               end
            end
            if (failed) begin
               emit(KIND_NUM, OPC_NONE, '0, '0, '0, fail_code);
               if (fail_code == ERR_PAREN)
                  paren_errors++;
               else
                  overflow_errors++;
            end else if (produced.size() == 0) begin
               emit(KIND_NUM, OPC_NONE, '0, '0, '0, ERR_NONE);
               empty_endings++;
            end
            w     = produced[produced.size() - 1];
            w.eoe = 1'b1;
            produced[produced.size() - 1] = w;
            depth     = 0;
            failed    = 1'b0;
            fail_code = ERR_NONE;
         end
         foreach (produced[i])
            postfix_due.insert(postfix_due.size(), produced[i]);
         return effective;
      endfunction

      // Compares one popped word with the oldest word still due.
      function void check_word(rsp_type got);
         rsp_type want;
         string   diffs;
         words_checked++;
         if (postfix_due.size() == 0) begin
            complain({"unexpected word: ", describe(got)});
            return;
         end
         want  = postfix_due.pop_front();
         diffs = "";
         if (got.tok.kind !== want.tok.kind)   diffs = {diffs, " kind"};
         if (got.tok.opc !== want.tok.opc)     diffs = {diffs, " operator"};
         if (got.tok.value !== want.tok.value) diffs = {diffs, " value"};
         if (got.tok.name !== want.tok.name)   diffs = {diffs, " name"};
         if (got.tok.argc !== want.tok.argc)   diffs = {diffs, " argc"};
         if (got.eoe !== want.eoe)             diffs = {diffs, " end"};
         if (got.err !== want.err)             diffs = {diffs, " error"};
         if (diffs != "")
            complain({"in", diffs, "\n   expected ", describe(want),
                      "\n   actual   ", describe(got)});
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        push;
   logic        full;
   logic [1:0]  req_op;
   logic [3:0]  req_operator_code;
   logic [63:0] req_value_bits;
   logic [7:0]  req_name_index;
   logic [3:0]  req_argument_count;
   logic        req_last_token;
   logic        empty;
   logic        pop;
   logic [1:0]  rsp_out_kind;
   logic [3:0]  rsp_out_operator;
   logic [63:0] rsp_out_value_bits;
   logic [7:0]  rsp_out_name_index;
   logic [3:0]  rsp_out_argument_count;
   logic        rsp_end_of_expression;
   logic [1:0]  rsp_error_code;

   postfix_scoreboard sb;
   infix_tok_type     infix_q[$];
   int                burst_left;
   int                tokens_sent;
   int                tokens_counted;

   infix_to_postfix_converter dut (
      .clock                  (clock),
      .reset                  (reset),
      .push                   (push),
      .full                   (full),
      .req_op                 (req_op),
      .req_operator_code      (req_operator_code),
      .req_value_bits         (req_value_bits),
      .req_name_index         (req_name_index),
      .req_argument_count     (req_argument_count),
      .req_last_token         (req_last_token),
      .empty                  (empty),
      .pop                    (pop),
      .rsp_out_kind           (rsp_out_kind),
      .rsp_out_operator       (rsp_out_operator),
      .rsp_out_value_bits     (rsp_out_value_bits),
      .rsp_out_name_index     (rsp_out_name_index),
      .rsp_out_argument_count (rsp_out_argument_count),
      .rsp_end_of_expression  (rsp_end_of_expression),
      .rsp_error_code         (rsp_error_code)
   );

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // Hard limit on the run, far beyond the slowest correct run.
   initial begin
      #10_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // A token of the given kind and code; value, name and argc carry random content, last stays low.
   function automatic infix_tok_type token(logic [1:0] kind, logic [3:0] opc);
      infix_tok_type t;
      t.kind = kind;
      t.opc  = opc;
      case ($urandom_range(0, 7))
         0:       t.value = '0;
         1:       t.value = '1;
         default: t.value = {$urandom, $urandom};
      endcase
      t.name = 8'($urandom_range(0, 255));
      t.argc = 4'($urandom_range(0, 15));
      t.last = 1'b0;
      return t;
   endfunction

   task automatic append_tok(logic [1:0] kind, logic [3:0] opc);
      infix_q.insert(infix_q.size(), token(kind, opc));
   endtask

   task automatic close_expr();
      infix_tok_type t;
      t      = infix_q[infix_q.size() - 1];
      t.last = 1'b1;
      infix_q[infix_q.size() - 1] = t;
   endtask

   // Random well-formed operand: number, variable, bracketed expression,
   // function call or a prefix operator.
   task automatic gen_operand(input int lvl);
      int pick;
      int args;
      pick = $urandom_range(0, (lvl > 0) ? 5 : 1);
      case (pick)
         0, 5: append_tok(KIND_NUM, OPC_NONE);
         1:    append_tok(KIND_VAR, OPC_NONE);
         2: begin
            append_tok(KIND_OPER, OPC_LPAREN);
            gen_expr(lvl - 1);
            append_tok(KIND_OPER, OPC_RPAREN);
         end
         3: begin
            append_tok(KIND_FUNC, OPC_NONE);
            append_tok(KIND_OPER, OPC_LPAREN);
            args = $urandom_range(1, 3);
            gen_expr(lvl - 1);
            repeat (args - 1) begin
               append_tok(KIND_OPER, OPC_COMMA);
               gen_expr(lvl - 1);
            end
            append_tok(KIND_OPER, OPC_RPAREN);
         end
         default: begin
            append_tok(KIND_OPER, ($urandom_range(0, 1) == 1) ? OPC_NEG : OPC_SQRT);
            gen_operand(lvl - 1);
         end
      endcase
   endtask

   task automatic gen_expr(input int lvl);
      int         terms;
      logic [3:0] binop;
      gen_operand(lvl);
      terms = $urandom_range(0, 3);
      repeat (terms) begin
         case ($urandom_range(0, 5))
            0:       binop = OPC_ADD;
            1:       binop = OPC_SUB;
            2:       binop = OPC_MUL;
            3:       binop = OPC_DIV;
            4:       binop = OPC_MOD;
            default: binop = OPC_POW;
         endcase
         append_tok(KIND_OPER, binop);
         gen_operand(lvl);
      end
   endtask

   // Deep bracket nesting around the stack limit.
   task automatic gen_nest(input int n);
      repeat (n) begin
         if ($urandom_range(0, 3) == 0)
            append_tok(KIND_FUNC, OPC_NONE);
         append_tok(KIND_OPER, OPC_LPAREN);
      end
      gen_expr(0);
      repeat (n)
         append_tok(KIND_OPER, OPC_RPAREN);
      close_expr();
   endtask

   task automatic gen_scenario(input shape_type shape);
      int            at;
      infix_tok_type t;
      case (shape)
         SHAPE_CLEAN: begin
            gen_expr($urandom_range(0, 3));
            close_expr();
         end
         SHAPE_NEST: gen_nest($urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 3));
         SHAPE_BROKEN: begin
            // A good expression with one bracket forced, or one token dropped.
            gen_expr(2);
            at = $urandom_range(0, infix_q.size() - 1);
            case ($urandom_range(0, 2))
               0: infix_q[at] = token(KIND_OPER, OPC_LPAREN);
               1: infix_q[at] = token(KIND_OPER, OPC_RPAREN);
               default: if (infix_q.size() > 1) infix_q.delete(at);
            endcase
            close_expr();
         end
         default: begin
            repeat ($urandom_range(1, 8)) begin
               t      = token(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
               t.last = ($urandom_range(0, 3) == 0);
               infix_q.insert(infix_q.size(), t);
            end
            close_expr();
         end
      endcase
   endtask

   // Pushes the queued tokens in bursts with random gaps between them.
   task automatic send_queue();
      infix_tok_type t;
      while (infix_q.size() > 0) begin
         t = infix_q.pop_front();
         if (burst_left == 0) begin
            push = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
            burst_left = ($urandom_range(0, 4) == 0) ? 80 : $urandom_range(1, 16);
         end
         burst_left--;
         push               = 1'b1;
         req_op             = t.kind;
         req_operator_code  = t.opc;
         req_value_bits     = t.value;
         req_name_index     = t.name;
         req_argument_count = t.argc;
         req_last_token     = t.last;
         @(posedge clock);
         while (full) @(posedge clock);
         if (sb.note_token(t))
            tokens_counted++;
         tokens_sent++;
         @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      push = 1'b0;
      while (sb.postfix_due.size() > 0) @(negedge clock);
   endtask

   // Receiver: pops on a stall pattern that switches to a random mode after each span of random length.
   initial begin
      drain_mode_type mode;
      int             span;
      pop = 1'b0;
      forever begin
         mode = drain_mode_type'($urandom_range(0, 3));
         span = $urandom_range(8, 64);
         repeat (span) begin
            @(negedge clock);
            case (mode)
               DRAIN_FREE:  pop = 1'b1;
               DRAIN_LIGHT: pop = ($urandom_range(0, 3) != 0);
               DRAIN_HALF:  pop = ($urandom_range(0, 1) == 1);
               default:     pop = ($urandom_range(0, 11) == 0);
            endcase
         end
      end
   end

   // Every popped word is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && pop && !empty)
         sb.check_word(rsp_type'{
            tok: tok_type'{rsp_out_kind, rsp_out_operator, rsp_out_value_bits,
                           rsp_out_name_index, rsp_out_argument_count},
            eoe: rsp_end_of_expression,
            err: rsp_error_code});
   end

   // Main sequence: reset, directed tokens, then random expressions.
   initial begin
      infix_tok_type t;
      int            r;
      sb                 = new();
      reset              = 1'b1;
      push               = 1'b0;
      req_op             = '0;
      req_operator_code  = '0;
      req_value_bits     = '0;
      req_name_index     = '0;
      req_argument_count = '0;
      req_last_token     = 1'b0;
      burst_left         = 0;
      tokens_sent        = 0;
      tokens_counted     = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // f(max, v + 0 * v / v % v - v ^ sqrt neg v) with field extremes.
      t      = token(KIND_FUNC, OPC_NONE);
      t.name = '1;
      t.argc = '1;
      infix_q.insert(infix_q.size(), t);
      append_tok(KIND_OPER, OPC_LPAREN);
      t       = token(KIND_NUM, OPC_NONE);
      t.value = '1;
      infix_q.insert(infix_q.size(), t);
      append_tok(KIND_OPER, OPC_COMMA);
      t      = token(KIND_VAR, OPC_NONE);
      t.name = '0;
      infix_q.insert(infix_q.size(), t);
      append_tok(KIND_OPER, OPC_ADD);
      t       = token(KIND_NUM, OPC_NONE);
      t.value = '0;
      infix_q.insert(infix_q.size(), t);
      append_tok(KIND_OPER, OPC_MUL);
      append_tok(KIND_VAR, OPC_NONE);
      append_tok(KIND_OPER, OPC_DIV);
      append_tok(KIND_VAR, OPC_NONE);
      append_tok(KIND_OPER, OPC_MOD);
      append_tok(KIND_VAR, OPC_NONE);
      append_tok(KIND_OPER, OPC_SUB);
      append_tok(KIND_VAR, OPC_NONE);
      append_tok(KIND_OPER, OPC_POW);
      append_tok(KIND_OPER, OPC_SQRT);
      append_tok(KIND_OPER, OPC_NEG);
      t      = token(KIND_VAR, OPC_NONE);
      t.name = '1;
      infix_q.insert(infix_q.size(), t);
      append_tok(KIND_OPER, OPC_RPAREN);
      close_expr();
      // Right parenthesis with nothing open, then a token the failed state drops.
      append_tok(KIND_OPER, OPC_RPAREN);
      append_tok(KIND_VAR, OPC_NONE);
      close_expr();
      // Left parenthesis still open at the flush.
      append_tok(KIND_OPER, OPC_LPAREN);
      append_tok(KIND_NUM, OPC_NONE);
      close_expr();
      // A comma on an empty stack, then an unknown code, each closing at once.
      append_tok(KIND_OPER, OPC_COMMA);
      close_expr();
      append_tok(KIND_OPER, OPC_BAD);
      close_expr();
      send_queue();
      wait_drained();

      // Overflow first, then a mix of expression shapes.
      gen_nest(STACK_DEPTH + 2);
      send_queue();
      while (tokens_sent < TOKEN_GOAL) begin
         r = $urandom_range(0, 99);
         if (r < 70)
            gen_scenario(SHAPE_CLEAN);
         else if (r < 78)
            gen_scenario(SHAPE_NEST);
         else if (r < 90)
            gen_scenario(SHAPE_BROKEN);
         else
            gen_scenario(SHAPE_NOISE);
         send_queue();
         if ($urandom_range(0, 9) == 0)
            wait_drained();
      end

      wait_drained();
      repeat (40) @(negedge clock);
      $display("Run covered %0d tokens (%0d acted on) in %0d expressions; %0d words checked.",
               tokens_sent, tokens_counted, sb.expressions, sb.words_checked);
      $display("Endings: %0d bracket errors, %0d overflows, %0d empty; %0d mismatches.",
               sb.paren_errors, sb.overflow_errors, sb.empty_endings, sb.mismatches);
      if (sb.mismatches == 0 && sb.postfix_due.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

@@ filelist.f @@
src/itp_pkg.sv
src/itp_front.sv
src/itp_rsp_fifo.sv
src/itp_back.sv
src/infix_to_postfix_converter.sv
tb/sv/tb.sv
